// ----- rtl/wsd_pkg.sv -----
package wsd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // header error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_FRAG_CTL = 3'd1;
    localparam logic [2:0] ERR_RSV_BIT  = 3'd2;
    localparam logic [2:0] ERR_BAD_OP   = 3'd3;
    localparam logic [2:0] ERR_UNMASKED = 3'd4;

    // frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'ha;

    // header field constants
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // one classified request from the parser to the unmask stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        logic [2:0] err;
    } cmd_t;

endpackage

// ----- rtl/wsd_front.sv -----
module wsd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    stream_byte,
    input  logic          new_connection,
    output logic          push,
    output wsd_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         fin_reg, fin_next;
    logic [3:0]   opcode_reg, opcode_next;
    logic [63:0]  rem_reg, rem_next;
    logic [2:0]   field_reg, field_next;
    logic [31:0]  key_reg, key_next;
    logic [1:0]   pos_reg, pos_next;

    phase_t       eff_phase;
    logic         eff_fin;
    logic [3:0]   eff_opcode;
    logic [63:0]  eff_rem;
    logic [2:0]   eff_field;
    logic [31:0]  eff_key;
    logic [1:0]   eff_pos;
    logic [63:0]  rem_dec;
    logic [3:0]   hdr_op;
    logic         bad_op;

    // a new connection restarts the parser before this byte is taken
    always_comb
    begin
        eff_phase  = new_connection ? PH_HDR1 : phase_reg;
        eff_fin    = new_connection ? 1'b0 : fin_reg;
        eff_opcode = new_connection ? 4'd0 : opcode_reg;
        eff_rem    = new_connection ? 64'd0 : rem_reg;
        eff_field  = new_connection ? 3'd0 : field_reg;
        eff_key    = new_connection ? 32'd0 : key_reg;
        eff_pos    = new_connection ? 2'd0 : pos_reg;
    end

    assign rem_dec = eff_rem - 64'd1;
    assign hdr_op  = stream_byte[3:0];
    assign bad_op  = (hdr_op > wsd_pkg::OP_BINARY && hdr_op < wsd_pkg::OP_CLOSE)
                     || hdr_op > wsd_pkg::OP_PONG;

    // header parse and request classification
    always_comb
    begin
        phase_next  = eff_phase;
        fin_next    = eff_fin;
        opcode_next = eff_opcode;
        rem_next    = eff_rem;
        field_next  = eff_field;
        key_next    = eff_key;
        pos_next    = eff_pos;
        push        = 1'b0;
        cmd.kind    = wsd_pkg::KIND_PAYLOAD;
        cmd.data    = stream_byte;
        cmd.key     = 8'd0;
        cmd.opcode  = eff_opcode;
        cmd.fin     = eff_fin;
        cmd.last    = 1'b1;
        cmd.err     = wsd_pkg::ERR_NONE;
        case (eff_phase)
            PH_HDR1:
            begin
                fin_next    = stream_byte[7];
                opcode_next = hdr_op;
                cmd.opcode  = hdr_op;
                cmd.fin     = stream_byte[7];
                cmd.kind    = wsd_pkg::KIND_ERROR;
                if (!stream_byte[7] && hdr_op[3])
                begin
                    push       = 1'b1;
                    cmd.err    = wsd_pkg::ERR_FRAG_CTL;
                    phase_next = PH_HALT;
                end
                else if (|stream_byte[6:4])
                begin
                    push       = 1'b1;
                    cmd.err    = wsd_pkg::ERR_RSV_BIT;
                    phase_next = PH_HALT;
                end
                else if (bad_op)
                begin
                    push       = 1'b1;
                    cmd.err    = wsd_pkg::ERR_BAD_OP;
                    phase_next = PH_HALT;
                end
                else
                begin
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2:
            begin
                if (!stream_byte[7])
                begin
                    push       = 1'b1;
                    cmd.kind   = wsd_pkg::KIND_ERROR;
                    cmd.err    = wsd_pkg::ERR_UNMASKED;
                    phase_next = PH_HALT;
                end
                else if (stream_byte[6:0] == wsd_pkg::LEN_EXT16)
                begin
                    rem_next   = 64'd0;
                    field_next = 3'd1;
                    phase_next = PH_EXTLEN;
                end
                else if (stream_byte[6:0] == wsd_pkg::LEN_EXT64)
                begin
                    rem_next   = 64'd0;
                    field_next = 3'd7;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    rem_next   = {57'd0, stream_byte[6:0]};
                    field_next = 3'd3;
                    phase_next = PH_MASK;
                end
            end
            PH_EXTLEN:
            begin
                rem_next = {eff_rem[55:0], stream_byte};
                if (eff_field == 3'd0)
                begin
                    field_next = 3'd3;
                    phase_next = PH_MASK;
                end
                else
                begin
                    field_next = eff_field - 3'd1;
                end
            end
            PH_MASK:
            begin
                key_next = {eff_key[23:0], stream_byte};
                if (eff_field != 3'd0)
                begin
                    field_next = eff_field - 3'd1;
                end
                else
                begin
                    pos_next = 2'd0;
                    if (eff_rem == 64'd0)
                    begin
                        push       = 1'b1;
                        cmd.kind   = wsd_pkg::KIND_EMPTY;
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                push     = 1'b1;
                rem_next = rem_dec;
                pos_next = eff_pos + 2'd1;
                cmd.last = (rem_dec == 64'd0);
                case (eff_pos)
                    2'd0:    cmd.key = eff_key[31:24];
                    2'd1:    cmd.key = eff_key[23:16];
                    2'd2:    cmd.key = eff_key[15:8];
                    default: cmd.key = eff_key[7:0];
                endcase
                if (rem_dec == 64'd0)
                begin
                    phase_next = PH_HDR1;
                end
            end
            default:
            begin
                phase_next = eff_phase;
            end
        endcase
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            rem_reg    <= 64'd0;
            field_reg  <= 3'd0;
            key_reg    <= 32'd0;
            pos_reg    <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            rem_reg    <= rem_next;
            field_reg  <= field_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
        end
    end

`ifndef SYNTHESIS
    // a halted parser stays silent until a new connection
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_HALT && !new_connection) |-> !push)
        else $error("wsd_front: request issued while halted");

    // payload phase always has bytes left to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (rem_reg != 64'd0))
        else $error("wsd_front: payload phase with zero length left");
`endif

endmodule

// ----- rtl/wsd_queue.sv -----
module wsd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wsd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output wsd_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    wsd_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // request storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("wsd_queue: fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("wsd_queue: fill count missed a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("wsd_queue: read from empty queue");
`endif

endmodule

// ----- rtl/wsd_back.sv -----
module wsd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  wsd_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_ready,
    output logic [1:0]    result_kind,
    output logic [7:0]    payload_byte,
    output logic [3:0]    frame_opcode,
    output logic          final_fragment,
    output logic          last_of_frame,
    output logic [2:0]    error_code
);

    logic       result_valid_reg, result_valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg, byte_next;
    logic [3:0] opcode_reg;
    logic       fin_reg;
    logic       last_reg;
    logic [2:0] err_reg;

    // take the next request when the output register is free or drains
    assign pop = head_valid && (!result_valid_reg || result_ready);

    // unmask payload bytes, other kinds carry a zero byte
    assign byte_next = (head_cmd.kind == wsd_pkg::KIND_PAYLOAD)
                       ? (head_cmd.data ^ head_cmd.key) : 8'd0;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pop)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head_cmd.kind;
            byte_reg   <= byte_next;
            opcode_reg <= head_cmd.opcode;
            fin_reg    <= head_cmd.fin;
            last_reg   <= head_cmd.last;
            err_reg    <= head_cmd.err;
        end
    end

    assign result_valid   = result_valid_reg;
    assign result_kind    = kind_reg;
    assign payload_byte   = byte_reg;
    assign frame_opcode   = opcode_reg;
    assign final_fragment = fin_reg;
    assign last_of_frame  = last_reg;
    assign error_code     = err_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == wsd_pkg::KIND_ERROR)
            |-> (last_of_frame && error_code != wsd_pkg::ERR_NONE))
        else $error("wsd_back: error result without code or end mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind != wsd_pkg::KIND_PAYLOAD) |-> (payload_byte == 8'd0))
        else $error("wsd_back: non-payload result carries data");
`endif

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// result path: an accepted request is registered into a queue entry, then into the output register (result_valid)
// throughput: one byte per cycle while the queue is not full, set by the header parser update
// (one 64-bit length decrement and zero compare per payload byte)
// a request queue of QUEUE_DEPTH entries decouples the parser from the output register
// reset: rst_n asynchronous, clears parser to header start and empties queue and output
module websocket_frame_deframer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] stream_byte,
    input  logic       new_connection,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] result_kind,
    output logic [7:0] payload_byte,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       last_of_frame,
    output logic [2:0] error_code
);

    logic          accept;
    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;
    wsd_pkg::cmd_t push_cmd;
    wsd_pkg::cmd_t head_cmd;

    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    // header parser and request classification
    wsd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .stream_byte    (stream_byte),
        .new_connection (new_connection),
        .push           (push),
        .cmd            (push_cmd)
    );

    // request queue
    wsd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push && accept),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // unmask and output register
    wsd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .last_of_frame  (last_of_frame),
        .error_code     (error_code)
    );

endmodule
